>>> rtl/hspc_pkg.sv
package hspc_pkg;

  localparam int TIME_W    = 32;
  localparam int SPEED_W   = 24;
  localparam int PWM_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int PPR_W     = 8;
  localparam int CNT_W     = 2;
  localparam int HIDX_W    = 2;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int INT_W     = 48;

  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 32;
  localparam int MUL_A_W   = 38;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

  localparam int DEF_MAX_SENSORS = 3;

  localparam logic [20:0]        SPEED_NUM = 21'd1608495;
  localparam logic [SPEED_W-1:0] SPEED_TOP = 24'hFF_FFFF;
  localparam logic [48:0]        INT_CAP   = 49'h1_0000_0000_0000;
  localparam logic [INT_W-1:0]   INT_HI    = 48'h7FFF_FFFF_FFFF;
  localparam logic [INT_W-1:0]   INT_LO    = 48'h8000_0000_0000;
  localparam logic [9:0]         MS_PER_S  = 10'd1000;

  // reciprocals of 1000: floor(2^47/1000), ceil(2^27/1000), ceil(2^36/1000)
  localparam logic [MUL_A_W-1:0] REC_HI  = 38'd140737488355;
  localparam logic [17:0]        REC_MID = 18'd134218;
  localparam logic [26:0]        REC_LO  = 27'd68719477;

  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN = 16'd256;
  localparam logic [GAIN_W-1:0]  RST_INT_GAIN  = 16'd0;
  localparam logic [SPEED_W-1:0] RST_MAX_SPEED = 24'd25600;
  localparam logic [PWM_W-1:0]   RST_PWM_MAX   = 12'd255;
  localparam logic [PWM_W-1:0]   RST_PWM_MIN   = 12'd0;
  localparam logic [CNT_W-1:0]   RST_SENS_CNT  = 2'd3;
  localparam logic [PPR_W-1:0]   RST_PPR       = 8'd6;
  localparam logic [15:0]        RST_TIMEOUT   = 16'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEGRAL_GAIN  = 3'd1,
    REG_MAX_SPEED      = 3'd2,
    REG_PWM_MAX        = 3'd3,
    REG_PWM_MIN        = 3'd4,
    REG_SENSOR_COUNT   = 3'd5,
    REG_PULSES_PER_REV = 3'd6,
    REG_STALL_TIMEOUT  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

>>> rtl/hspc_if.sv
interface hspc_req_if;
  import hspc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [HIDX_W-1:0]         hall_index;
  logic [TIME_W-1:0]         now_ms;
  logic signed [SPEED_W-1:0] desired_speed;

  modport source (output valid, cmd, hall_index, now_ms, desired_speed, input ready);
  modport sink (input valid, cmd, hall_index, now_ms, desired_speed, output ready);
endinterface

interface hspc_rsp_if;
  import hspc_pkg::*;
  logic               valid;
  logic               ready;
  logic [PWM_W-1:0]   pwm;
  logic [SPEED_W-1:0] measured_speed;

  modport source (output valid, pwm, measured_speed, input ready);
  modport sink (input valid, pwm, measured_speed, output ready);
endinterface

>>> rtl/hall_speed_pi_motor_controller_unit.sv
// a pulse request is taken while idle, with no response, one pulse per cycle
// a command request reads each averaged sensor in turn, dividing for each with two
// pulses and a usable gap, then averages them and forms the PI terms to the response
// the sensor speeds, the average and the bias wait on the shared restoring divider
// one command at a time, held in done while the response is stalled
// reset (synchronous, active high) restores defaults, clears pulse and integral state
module hall_speed_pi_motor_controller_unit #(
  parameter int MAX_SENSORS = hspc_pkg::DEF_MAX_SENSORS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hspc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hspc_pkg::CFG_W-1:0]     cfg_data,
  hspc_req_if.sink                       req,
  hspc_rsp_if.source                     rsp
);
  import hspc_pkg::*;

  localparam int SIDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int SUM_W  = SPEED_W + $clog2(MAX_SENSORS + 1);

  typedef enum logic [24:0] {
    ST_IDLE  = 25'd1 << 0,
    ST_SENS  = 25'd1 << 1,
    ST_SMUL  = 25'd1 << 2,
    ST_SDIV  = 25'd1 << 3,
    ST_SDIVW = 25'd1 << 4,
    ST_AVG   = 25'd1 << 5,
    ST_AVGW  = 25'd1 << 6,
    ST_ERR   = 25'd1 << 7,
    ST_IMUL  = 25'd1 << 8,
    ST_ICAND = 25'd1 << 9,
    ST_BMUL  = 25'd1 << 10,
    ST_BDIV  = 25'd1 << 11,
    ST_BDIVW = 25'd1 << 12,
    ST_PMUL  = 25'd1 << 13,
    ST_CMUL  = 25'd1 << 14,
    ST_CQ0   = 25'd1 << 15,
    ST_CR0   = 25'd1 << 16,
    ST_CQ1   = 25'd1 << 17,
    ST_CR1   = 25'd1 << 18,
    ST_QMUL  = 25'd1 << 19,
    ST_RMUL  = 25'd1 << 20,
    ST_RREC  = 25'd1 << 21,
    ST_RQ    = 25'd1 << 22,
    ST_SUM   = 25'd1 << 23,
    ST_DONE  = 25'd1 << 24
  } state_t;

  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integral_gain;
  logic [SPEED_W-1:0] max_speed;
  logic [PWM_W-1:0]   pwm_max;
  logic [PWM_W-1:0]   pwm_min;
  logic [CNT_W-1:0]   sensor_count;
  logic [PPR_W-1:0]   pulses_per_rev;
  logic [15:0]        stall_timeout_ms;

  logic [TIME_W-1:0]  last_pulse_time    [MAX_SENSORS];
  logic [TIME_W-1:0]  earlier_pulse_time [MAX_SENSORS];
  logic [1:0]         pulses_seen        [MAX_SENSORS];
  logic [SPEED_W-1:0] sensor_speed       [MAX_SENSORS];
  logic signed [INT_W-1:0] error_integral;
  logic [TIME_W-1:0]  last_command_time;
  logic               command_time_valid;

  state_t                    state;
  logic [SIDX_W-1:0]         sidx;
  logic [TIME_W-1:0]         now_r;
  logic signed [SPEED_W-1:0] desired_r;
  logic [SUM_W-1:0]          speed_sum;
  logic [SPEED_W-1:0]        measured;
  logic signed [25:0]        err;
  logic [TIME_W-1:0]         dt;
  logic signed [INT_W-1:0]   cand;
  logic signed [52:0]        bias;
  logic signed [42:0]        pterm;
  logic [37:0]               cq;
  logic [16:0]               cr0;
  logic [9:0]                cr;
  logic [53:0]               iq;
  logic signed [55:0]        iterm;
  logic signed [57:0]        acc;

  logic               rsp_valid;
  logic [PWM_W-1:0]   rsp_pwm;
  logic [SPEED_W-1:0] rsp_speed;

  div_req_t           dreq;
  div_rsp_t           drsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  logic [CNT_W-1:0]   count_c;
  logic [SPEED_W-1:0] ms;
  logic [TIME_W-1:0]  cur_last;
  logic [TIME_W-1:0]  gap;
  logic               stall;
  logic               need_div;
  logic [SPEED_W-1:0] spd_imm;
  logic [SPEED_W-1:0] spd_w;
  logic               spd_done;
  logic               last_sensor;
  logic [24:0]        eabs;
  logic [23:0]        dabs;
  logic [INT_W-1:0]   cabs;
  logic [INT_W-1:0]   rem0_w;
  logic [16:0]        rem1_w;
  logic [48:0]        mag;
  logic signed [49:0] cand_w;
  logic signed [INT_W-1:0] cand_sat;
  logic [54:0]        imag;
  logic signed [57:0] acc_adj;
  logic signed [41:0] counts;
  logic [PWM_W-1:0]   pwm_val;
  logic               commit;
  logic               load;
  logic               req_take;

  hspc_div u_div (.clk(clk), .rst(rst), .dreq(dreq), .drsp(drsp));
  hspc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  always_comb begin
    count_c = (sensor_count == '0) ? CNT_W'(1) : sensor_count;
    if (32'(count_c) > MAX_SENSORS) count_c = CNT_W'(MAX_SENSORS);
  end

  assign ms          = (max_speed == '0) ? SPEED_W'(1) : max_speed;
  assign last_sensor = (sidx == SIDX_W'(count_c - CNT_W'(1)));

  // per-sensor speed
  assign cur_last = last_pulse_time[sidx];
  assign gap      = cur_last - earlier_pulse_time[sidx];
  assign stall    = (now_r - cur_last) > TIME_W'(stall_timeout_ms);

  always_comb begin
    need_div = 1'b0;
    spd_imm  = '0;
    if (pulses_seen[sidx] == 2'd1) begin
      spd_imm = sensor_speed[sidx];
    end else if (pulses_seen[sidx] != 2'd0) begin
      if (gap == '0 || pulses_per_rev == '0) spd_imm = SPEED_TOP;
      else if (gap > TIME_W'(SPEED_NUM)) spd_imm = '0;
      else need_div = 1'b1;
    end
  end

  assign spd_w    = stall ? '0 : ((state == ST_SDIVW) ? drsp.quot[SPEED_W-1:0] : spd_imm);
  assign spd_done = (state == ST_SENS && !need_div) || (state == ST_SDIVW && drsp.done);

  // control terms
  assign eabs = err[25] ? 25'(-err) : 25'(err);
  assign dabs = desired_r[SPEED_W-1] ? 24'(-desired_r) : 24'(desired_r);
  assign cabs = cand[INT_W-1] ? INT_W'(-cand) : INT_W'(cand);
  assign mag  = (mul_p > MUL_P_W'(INT_CAP)) ? INT_CAP : mul_p[48:0];
  assign cand_w = $signed({{2{error_integral[INT_W-1]}}, error_integral})
                + (err[25] ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));

  always_comb begin
    if (cand_w[49:47] == 3'b000 || cand_w[49:47] == 3'b111) cand_sat = cand_w[INT_W-1:0];
    else if (cand_w[49]) cand_sat = INT_LO;
    else cand_sat = INT_HI;
  end

  // integral divide by 1000: coarse reciprocal quotient, then exact fix-up of remainder
  assign rem0_w  = cabs - mul_p[INT_W-1:0];
  assign rem1_w  = cr0 - mul_p[16:0];
  assign imag    = 55'(iq) + 55'(mul_p[52:36]);
  assign acc_adj = acc[57] ? acc + 58'sd65535 : acc;
  assign counts  = acc_adj[57:16];

  always_comb begin
    if (counts < $signed({30'b0, pwm_min})) pwm_val = pwm_min;
    else if (counts > $signed({30'b0, pwm_max})) pwm_val = pwm_max;
    else pwm_val = counts[PWM_W-1:0];
  end

  assign commit   = (pwm_val != pwm_min) && (pwm_val != pwm_max);
  assign load     = (state == ST_DONE) && (!rsp_valid || rsp.ready);
  assign req_take = req.valid && req.ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SMUL: begin mul_a = MUL_A_W'(gap[20:0]); mul_b = MUL_B_W'(pulses_per_rev); end
      ST_IMUL: begin mul_a = MUL_A_W'(eabs); mul_b = dt; end
      ST_BMUL: begin mul_a = MUL_A_W'(dabs); mul_b = MUL_B_W'(pwm_max); end
      ST_PMUL: begin mul_a = MUL_A_W'(eabs); mul_b = MUL_B_W'(prop_gain); end
      ST_CMUL: begin mul_a = REC_HI; mul_b = cabs[47:16]; end
      ST_CQ0:  begin mul_a = mul_p[68:31]; mul_b = MUL_B_W'(MS_PER_S); end
      ST_CR0:  begin mul_a = MUL_A_W'(rem0_w[16:0]); mul_b = MUL_B_W'(REC_MID); end
      ST_CQ1:  begin mul_a = MUL_A_W'(mul_p[33:27]); mul_b = MUL_B_W'(MS_PER_S); end
      ST_QMUL: begin mul_a = cq; mul_b = MUL_B_W'(integral_gain); end
      ST_RMUL: begin mul_a = MUL_A_W'(cr); mul_b = MUL_B_W'(integral_gain); end
      ST_RREC: begin mul_a = MUL_A_W'(mul_p[25:0]); mul_b = MUL_B_W'(REC_LO); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // shared divider operand select
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    case (state)
      ST_SDIV: begin
        dreq.start = 1'b1;
        dreq.num   = DIV_NUM_W'(SPEED_NUM);
        dreq.den   = mul_p[DIV_DEN_W-1:0];
      end
      ST_AVG: begin
        dreq.start = 1'b1;
        dreq.num   = DIV_NUM_W'(speed_sum);
        dreq.den   = DIV_DEN_W'(count_c);
      end
      ST_BDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {mul_p[39:0], 16'b0};
        dreq.den   = DIV_DEN_W'(ms);
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= RST_PROP_GAIN;
      integral_gain    <= RST_INT_GAIN;
      max_speed        <= RST_MAX_SPEED;
      pwm_max          <= RST_PWM_MAX;
      pwm_min          <= RST_PWM_MIN;
      sensor_count     <= RST_SENS_CNT;
      pulses_per_rev   <= RST_PPR;
      stall_timeout_ms <= RST_TIMEOUT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PROP_GAIN:      prop_gain        <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN:  integral_gain    <= cfg_data[GAIN_W-1:0];
        REG_MAX_SPEED:      max_speed        <= cfg_data[SPEED_W-1:0];
        REG_PWM_MAX:        pwm_max          <= cfg_data[PWM_W-1:0];
        REG_PWM_MIN:        pwm_min          <= cfg_data[PWM_W-1:0];
        REG_SENSOR_COUNT:   sensor_count     <= cfg_data[CNT_W-1:0];
        REG_PULSES_PER_REV: pulses_per_rev   <= cfg_data[PPR_W-1:0];
        REG_STALL_TIMEOUT:  stall_timeout_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      sidx               <= '0;
      rsp_valid          <= 1'b0;
      error_integral     <= '0;
      last_command_time  <= '0;
      command_time_valid <= 1'b0;
      for (int i = 0; i < MAX_SENSORS; i++) begin
        last_pulse_time[i]    <= '0;
        earlier_pulse_time[i] <= '0;
        pulses_seen[i]        <= '0;
        sensor_speed[i]       <= '0;
      end
    end else begin
      if (load) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;

      if (spd_done) begin
        sensor_speed[sidx] <= spd_w;
        speed_sum          <= speed_sum + SUM_W'(spd_w);
      end

      case (state)
        ST_IDLE: begin
          if (req_take) begin
            now_r     <= req.now_ms;
            desired_r <= req.desired_speed;
            sidx      <= '0;
            speed_sum <= '0;
            if (req.cmd) begin
              state <= ST_SENS;
            end else if (32'(req.hall_index) < MAX_SENSORS) begin
              earlier_pulse_time[SIDX_W'(req.hall_index)] <=
                last_pulse_time[SIDX_W'(req.hall_index)];
              last_pulse_time[SIDX_W'(req.hall_index)] <= req.now_ms;
              if (pulses_seen[SIDX_W'(req.hall_index)] < 2'd2) begin
                pulses_seen[SIDX_W'(req.hall_index)] <=
                  pulses_seen[SIDX_W'(req.hall_index)] + 2'd1;
              end
            end
          end
        end
        ST_SENS: begin
          if (need_div) state <= ST_SMUL;
          else if (last_sensor) state <= ST_AVG;
          else sidx <= sidx + 1'b1;
        end
        ST_SMUL:  state <= ST_SDIV;
        ST_SDIV:  state <= ST_SDIVW;
        ST_SDIVW: begin
          if (drsp.done) begin
            if (last_sensor) state <= ST_AVG;
            else begin
              sidx  <= sidx + 1'b1;
              state <= ST_SENS;
            end
          end
        end
        ST_AVG:   state <= ST_AVGW;
        ST_AVGW: begin
          if (drsp.done) begin
            measured <= drsp.quot[SPEED_W-1:0];
            state    <= ST_ERR;
          end
        end
        ST_ERR: begin
          err   <= 26'(desired_r) - $signed({2'b0, measured});
          dt    <= command_time_valid ? now_r - last_command_time : '0;
          state <= ST_IMUL;
        end
        ST_IMUL:  state <= ST_ICAND;
        ST_ICAND: begin
          cand  <= cand_sat;
          state <= ST_BMUL;
        end
        ST_BMUL:  state <= ST_BDIV;
        ST_BDIV:  state <= ST_BDIVW;
        ST_BDIVW: begin
          if (drsp.done) begin
            bias  <= desired_r[SPEED_W-1] ? -$signed({1'b0, drsp.quot[51:0]})
                                          : $signed({1'b0, drsp.quot[51:0]});
            state <= ST_PMUL;
          end
        end
        ST_PMUL:  state <= ST_CMUL;
        ST_CMUL: begin
          pterm <= err[25] ? -$signed({1'b0, mul_p[41:0]}) : $signed({1'b0, mul_p[41:0]});
          state <= ST_CQ0;
        end
        ST_CQ0: begin
          cq    <= mul_p[68:31];
          state <= ST_CR0;
        end
        ST_CR0: begin
          cr0   <= rem0_w[16:0];
          state <= ST_CQ1;
        end
        ST_CQ1: begin
          cq    <= cq + MUL_A_W'(mul_p[33:27]);
          state <= ST_CR1;
        end
        ST_CR1: begin
          cr    <= rem1_w[9:0];
          state <= ST_QMUL;
        end
        ST_QMUL:  state <= ST_RMUL;
        ST_RMUL: begin
          iq    <= mul_p[53:0];
          state <= ST_RREC;
        end
        ST_RREC:  state <= ST_RQ;
        ST_RQ: begin
          iterm <= cand[INT_W-1] ? -$signed({1'b0, imag}) : $signed({1'b0, imag});
          state <= ST_SUM;
        end
        ST_SUM: begin
          acc   <= 58'(bias) + 58'(pterm) + 58'(iterm);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (load) begin
            rsp_pwm            <= pwm_val;
            rsp_speed          <= measured;
            if (commit) error_integral <= cand;
            last_command_time  <= now_r;
            command_time_valid <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req.ready          = (state == ST_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.pwm            = rsp_pwm;
  assign rsp.measured_speed = rsp_speed;
endmodule

>>> rtl/hspc_div.sv
module hspc_div (
  input  logic                clk,
  input  logic                rst,
  input  hspc_pkg::div_req_t  dreq,
  output hspc_pkg::div_rsp_t  drsp
);
  import hspc_pkg::*;

  localparam int STEP_W = $clog2(DIV_NUM_W);

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    step;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  assign trial = {rem, quo[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= dreq.num;
        rem  <= '0;
        den  <= dreq.den;
      end else if (busy) begin
        if (!diff[DIV_DEN_W]) begin
          rem <= diff[DIV_DEN_W-1:0];
          quo <= {quo[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DIV_DEN_W-1:0];
          quo <= {quo[DIV_NUM_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign drsp.done = done;
  assign drsp.quot = quo;
  assign drsp.rem  = rem;
endmodule

>>> rtl/hspc_mul.sv
module hspc_mul (
  input  logic                         clk,
  input  logic [hspc_pkg::MUL_A_W-1:0] a,
  input  logic [hspc_pkg::MUL_B_W-1:0] b,
  output logic [hspc_pkg::MUL_P_W-1:0] p
);
  import hspc_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end
endmodule

>>> rtl/hspc_checker.sv
module hspc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         req_cmd,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [hspc_pkg::PWM_W-1:0]   rsp_pwm,
  input logic [hspc_pkg::SPEED_W-1:0] rsp_measured_speed
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd |=> !req_ready)
    else $error("ready after command request");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_pwm) && $stable(rsp_measured_speed))
    else $error("response payload changed while stalled");

endmodule

bind hall_speed_pi_motor_controller_unit hspc_checker u_hspc_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_cmd            (req.cmd),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_pwm            (rsp.pwm),
  .rsp_measured_speed (rsp.measured_speed)
);
